### rtl/core/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg: shared constants for the seconds-to-calendar converter
// Day and year lengths, the century limit and the month length table.
// ----------------------------------------------------------------------------
package stc_pkg;

   localparam int unsigned SecsPerDay = 86400;
   localparam int unsigned CenturyDays = 36525;
   localparam int unsigned QuadDays = 1461;

   // days in month, index 0 is January; leap selects 29 days for February
   function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
      logic [4:0] d;
      case (mon)
         4'd1: d = leap ? 5'd29 : 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10: d = 5'd30;
         default: d = 5'd31;
      endcase
      return d;
   endfunction

endpackage

### rtl/core/seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// seconds_to_calendar: seconds count since 2000-01-01 to calendar date/time
// Pipelined converter: one item may enter every cycle.
//
//   channel   ports                         direction
//   request   start, busy, req_*            in (busy always low)
//   response  rsp_valid, rsp_*              out, one-cycle strobe
//
// rsp_valid is the last valid bit, in step with the stage 7 registers, and
// a new item is taken every cycle. The depth is set by the reciprocal
// multiplies (days, minutes, hours, four-year groups) and the month walk.
// Reset clears the valid bits only. The receiver cannot stall, so nothing
// is held back.
// ----------------------------------------------------------------------------
module seconds_to_calendar (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_counter_seconds,
   output logic        rsp_valid,
   output logic [6:0]  rsp_year_offset,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day,
   output logic [4:0]  rsp_hours,
   output logic [5:0]  rsp_minutes,
   output logic [5:0]  rsp_secs,
   output logic [2:0]  rsp_weekday,
   output logic        rsp_out_of_range
);
   import stc_pkg::*;

   logic [6:0] vld_ff, vld_in;

   // stage 1: days = cnt / 86400, minutes = cnt / 60 (reciprocal products)
   logic [31:0] s1_cnt_ff;
   logic [63:0] s1_dprod_ff, s1_mprod_ff;
   // stage 2: correct quotients, range check, secs
   logic [15:0] s2_days_ff;
   logic [25:0] s2_min_ff;
   logic [5:0]  s2_secs_ff;
   logic        s2_oor_ff;
   // stage 3: hours = min/60, minute rem; quad = days/1461
   logic [25:0] s3_min_ff;
   logic [15:0] s3_days_ff;
   logic [5:0]  s3_secs_ff;
   logic        s3_oor_ff;
   logic [47:0] s3_hprod_ff;
   logic [31:0] s3_qprod_ff;
   // stage 4: hour, minute, quad group and day in group
   logic [4:0]  s4_hours_ff;
   logic [5:0]  s4_minutes_ff, s4_secs_ff;
   logic [4:0]  s4_quad_ff;
   logic [10:0] s4_dq_ff;
   logic [15:0] s4_days_ff;
   logic        s4_oor_ff;
   // stage 5: year in group, day of year
   logic [6:0]  s5_year_ff;
   logic [8:0]  s5_doy_ff;
   logic [15:0] s5_days_ff;
   logic        s5_leap_ff, s5_oor_ff;
   logic [4:0]  s5_hours_ff;
   logic [5:0]  s5_minutes_ff, s5_secs_ff;
   // stage 6: first half of the month walk (Jan..Jun)
   logic [3:0]  s6_mon_ff;
   logic [8:0]  s6_rem_ff;
   logic [6:0]  s6_year_ff;
   logic [15:0] s6_days_ff;
   logic        s6_leap_ff, s6_oor_ff;
   logic [4:0]  s6_hours_ff;
   logic [5:0]  s6_minutes_ff, s6_secs_ff;
   // stage 7: second half of month walk, weekday from day count
   logic [3:0]  s7_mon_ff;
   logic [4:0]  s7_day_ff;
   logic [6:0]  s7_year_ff;
   logic [2:0]  s7_wd_ff;
   logic        s7_oor_ff;
   logic [4:0]  s7_hours_ff;
   logic [5:0]  s7_minutes_ff, s7_secs_ff;

   assign busy = 1'b0;
   assign vld_in = {vld_ff[5:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // quotient corrections and walk logic
   logic [31:0] d_q, m_q;
   logic [47:0] d_rem;
   logic [37:0] m_rem;
   logic [15:0] d_fix;
   logic [25:0] m_fix;
   logic [19:0] h_q;
   logic [31:0] h_rem;
   logic [19:0] h_fix;
   logic [5:0]  min_r;
   logic [4:0]  hr_r;
   logic [4:0]  q_q;
   logic [15:0] q_rem;
   logic [4:0]  q_fix;
   logic [10:0] dq_r;
   logic [1:0]  yq;
   logic [8:0]  doy;
   logic [3:0]  m6;
   logic [8:0]  r6;
   logic [3:0]  m7;
   logic [8:0]  r7;
   logic [17:0] w_x;
   logic [5:0]  w_s;
   logic [3:0]  w_f;
   logic [2:0]  w_g;
   logic [2:0]  wd;

   always_comb begin
      // cnt/86400 : floor(2^48/86400), low by at most one, fixed here
      d_q   = 32'(s1_dprod_ff[63:48]);
      d_rem = 48'(s1_cnt_ff) - 48'(d_q) * 48'(SecsPerDay);
      d_fix = (d_rem >= 48'(SecsPerDay)) ? 16'(d_q + 32'd1) : 16'(d_q);
      m_q   = s1_mprod_ff[63:32];
      m_rem = 38'(s1_cnt_ff) - 38'(m_q) * 38'd60;
      m_fix = (m_rem >= 38'd60) ? 26'(m_q + 32'd1) : 26'(m_q);
      // hours = minutes/60, quad = days/1461
      h_q   = s3_hprod_ff[45:26];
      h_rem = 32'(s3_min_ff) - 32'(h_q) * 32'd60;
      h_fix = (h_rem >= 32'd60) ? h_q + 20'd1 : h_q;
      min_r = (h_rem >= 32'd60) ? 6'(h_rem - 32'd60) : 6'(h_rem);
      // hour of day: total hours less whole days
      hr_r  = 5'(h_fix - 20'(s3_days_ff) * 20'd24);
      q_q   = 5'(s3_qprod_ff[31:26]);
      q_rem = s3_days_ff - 16'(q_q) * 16'(QuadDays);
      q_fix = (q_rem >= 16'(QuadDays)) ? q_q + 5'd1 : q_q;
      dq_r  = (q_rem >= 16'(QuadDays)) ? 11'(q_rem - 16'(QuadDays)) : 11'(q_rem);
      // year inside a four-year group: first year is leap
      if (s4_dq_ff < 11'd366) begin
         yq = 2'd0; doy = 9'(s4_dq_ff);
      end else if (s4_dq_ff < 11'd731) begin
         yq = 2'd1; doy = 9'(s4_dq_ff - 11'd366);
      end else if (s4_dq_ff < 11'd1096) begin
         yq = 2'd2; doy = 9'(s4_dq_ff - 11'd731);
      end else begin
         yq = 2'd3; doy = 9'(s4_dq_ff - 11'd1096);
      end
      // month walk: January to June first, then July to November in the next stage
      m6 = 4'd0; r6 = s5_doy_ff;
      for (int i = 0; i < 6; i++) begin
         if (m6 == 4'(i) && r6 >= 9'(month_days(4'(i), s5_leap_ff))) begin
            r6 = r6 - 9'(month_days(4'(i), s5_leap_ff));
            m6 = m6 + 4'd1;
         end
      end
      m7 = s6_mon_ff; r7 = s6_rem_ff;
      for (int i = 6; i < 11; i++) begin
         if (m7 == 4'(i) && r7 >= 9'(month_days(4'(i), s6_leap_ff))) begin
            r7 = r7 - 9'(month_days(4'(i), s6_leap_ff));
            m7 = m7 + 4'd1;
         end
      end
      // 2000-01-01 was a Saturday; mod 7 by folding octal digits (8 = 1 mod 7)
      w_x = 18'(s6_days_ff) + 18'd6;
      w_s = 6'(w_x[17:15]) + 6'(w_x[14:12]) + 6'(w_x[11:9]) + 6'(w_x[8:6])
          + 6'(w_x[5:3]) + 6'(w_x[2:0]);
      w_f = 4'(w_s[5:3]) + 4'(w_s[2:0]);
      w_g = 3'(4'(w_f[3]) + 4'(w_f[2:0]));
      wd  = (w_g == 3'd7) ? 3'd0 : w_g;
   end

   always_ff @(posedge clock) begin
      s1_cnt_ff   <= req_counter_seconds;
      s1_dprod_ff <= 64'(req_counter_seconds) * 64'd3257812230;
      s1_mprod_ff <= 64'(req_counter_seconds) * 64'd71582788;

      s2_days_ff <= d_fix;
      s2_min_ff  <= m_fix;
      s2_secs_ff <= (m_rem >= 38'd60) ? 6'(m_rem - 38'd60) : 6'(m_rem);
      s2_oor_ff  <= (d_fix >= 16'(CenturyDays));

      s3_min_ff   <= s2_min_ff;
      s3_days_ff  <= s2_days_ff;
      s3_secs_ff  <= s2_secs_ff;
      s3_oor_ff   <= s2_oor_ff;
      s3_hprod_ff <= 48'(s2_min_ff) * 48'd1118481;
      s3_qprod_ff <= 32'(s2_days_ff) * 32'd45931;

      s4_hours_ff   <= hr_r;
      s4_minutes_ff <= min_r;
      s4_secs_ff    <= s3_secs_ff;
      s4_quad_ff    <= q_fix;
      s4_dq_ff      <= dq_r;
      s4_days_ff    <= s3_days_ff;
      s4_oor_ff     <= s3_oor_ff;

      s5_year_ff    <= {s4_quad_ff, yq};
      s5_doy_ff     <= doy;
      s5_leap_ff    <= (yq == 2'd0);
      s5_days_ff    <= s4_days_ff;
      s5_oor_ff     <= s4_oor_ff;
      s5_hours_ff   <= s4_hours_ff;
      s5_minutes_ff <= s4_minutes_ff;
      s5_secs_ff    <= s4_secs_ff;

      s6_mon_ff     <= m6;
      s6_rem_ff     <= r6;
      s6_year_ff    <= s5_year_ff;
      s6_days_ff    <= s5_days_ff;
      s6_leap_ff    <= s5_leap_ff;
      s6_oor_ff     <= s5_oor_ff;
      s6_hours_ff   <= s5_hours_ff;
      s6_minutes_ff <= s5_minutes_ff;
      s6_secs_ff    <= s5_secs_ff;

      s7_mon_ff     <= m7 + 4'd1;
      s7_day_ff     <= 5'(r7 + 9'd1);
      s7_year_ff    <= s6_year_ff;
      s7_wd_ff      <= wd;
      s7_oor_ff     <= s6_oor_ff;
      s7_hours_ff   <= s6_hours_ff;
      s7_minutes_ff <= s6_minutes_ff;
      s7_secs_ff    <= s6_secs_ff;
   end

   // out-of-range items show all fields zero
   assign rsp_valid        = vld_ff[6];
   assign rsp_out_of_range = s7_oor_ff;
   assign rsp_year_offset  = s7_oor_ff ? '0 : s7_year_ff;
   assign rsp_month        = s7_oor_ff ? '0 : s7_mon_ff;
   assign rsp_day          = s7_oor_ff ? '0 : s7_day_ff;
   assign rsp_hours        = s7_oor_ff ? '0 : s7_hours_ff;
   assign rsp_minutes      = s7_oor_ff ? '0 : s7_minutes_ff;
   assign rsp_secs         = s7_oor_ff ? '0 : s7_secs_ff;
   assign rsp_weekday      = s7_oor_ff ? '0 : s7_wd_ff;

endmodule

### tb/tb_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// tb_seconds_to_calendar: self-checking bench for the seconds-to-calendar unit
// Drives seconds counts through the start/busy port, predicts the calendar
// date, time of day, weekday and range flag for each item, and compares every
// response strobe against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_seconds_to_calendar;
   timeunit 1ns;
   timeprecision 1ps;
   import stc_pkg::*;

   localparam int unsigned LastCount = 32'd3155759999; // 2099-12-31 23:59:59
   localparam int unsigned CycleLimit = 400000;

   typedef struct packed {
      logic [6:0] year_offset;
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] secs;
      logic [2:0] weekday;
      logic       out_of_range;
   } calendar_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [31:0] req_counter_seconds = '0;
   logic        rsp_valid;
   logic [6:0]  rsp_year_offset;
   logic [3:0]  rsp_month;
   logic [4:0]  rsp_day;
   logic [4:0]  rsp_hours;
   logic [5:0]  rsp_minutes;
   logic [5:0]  rsp_secs;
   logic [2:0]  rsp_weekday;
   logic        rsp_out_of_range;

   calendar_type pending_dates[$];
   int          error_count = 0;
   int unsigned cycle_count = 0;

   seconds_to_calendar dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // weekday from year offset, month and day (Sunday is 0)
   function automatic int unsigned weekday_of(int unsigned yoff, int unsigned mon,
                                              int unsigned dom);
      int unsigned y;
      int unsigned w;
      y = 2000 + yoff;
      if (mon < 3)
         w = (23 * mon) / 9 + dom + 4 + y + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400;
      else
         w = (23 * mon) / 9 + dom + 4 + y + y / 4 - y / 100 + y / 400 - 2;
      return w % 7;
   endfunction

   // calendar breakdown of one seconds count
   function automatic calendar_type calendar_of(logic [31:0] count);
      calendar_type c;
      int unsigned days;
      int unsigned year;
      int unsigned mon;
      int unsigned ylen;
      int unsigned mlen;
      int unsigned mlens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      c = '0;
      days = count / 86400;
      year = 0;
      mon = 0;
      if (days >= 36525) begin
         c.out_of_range = 1'b1;
         return c;
      end
      forever begin
         ylen = (year % 4 == 0) ? 366 : 365;
         if (days < ylen) break;
         days -= ylen;
         year++;
      end
      while (mon < 12) begin
         mlen = (mon == 1 && year % 4 == 0) ? 29 : mlens[mon];
         if (days < mlen) break;
         days -= mlen;
         mon++;
      end
      c.year_offset = 7'(year);
      c.month = 4'(mon + 1);
      c.day = 5'(days + 1);
      c.hours = 5'((count / 3600) % 24);
      c.minutes = 6'((count / 60) % 60);
      c.secs = 6'(count % 60);
      c.weekday = 3'(weekday_of(year, mon + 1, days + 1));
      return c;
   endfunction

   // checker: one response per strobe, oldest prediction first
   always @(posedge clock) begin
      calendar_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (pending_dates.size() == 0) begin
            $error("response with no pending item");
            error_count++;
         end else begin
            want = pending_dates.pop_front();
            if (rsp_year_offset !== want.year_offset) begin
               $error("year_offset exp %0d got %0d", want.year_offset, rsp_year_offset);
               error_count++;
            end
            if (rsp_month !== want.month) begin
               $error("month exp %0d got %0d", want.month, rsp_month);
               error_count++;
            end
            if (rsp_day !== want.day) begin
               $error("day exp %0d got %0d", want.day, rsp_day);
               error_count++;
            end
            if (rsp_hours !== want.hours) begin
               $error("hours exp %0d got %0d", want.hours, rsp_hours);
               error_count++;
            end
            if (rsp_minutes !== want.minutes) begin
               $error("minutes exp %0d got %0d", want.minutes, rsp_minutes);
               error_count++;
            end
            if (rsp_secs !== want.secs) begin
               $error("secs exp %0d got %0d", want.secs, rsp_secs);
               error_count++;
            end
            if (rsp_weekday !== want.weekday) begin
               $error("weekday exp %0d got %0d", want.weekday, rsp_weekday);
               error_count++;
            end
            if (rsp_out_of_range !== want.out_of_range) begin
               $error("out_of_range exp %0d got %0d", want.out_of_range, rsp_out_of_range);
               error_count++;
            end
         end
      end
   end

   // watchdog
   initial begin
      wait (cycle_count >= CycleLimit);
      $display("Regression FAIL");
      $finish;
   end

   // send one item; start stays high until a gap or a drain drops it
   task automatic send_count(logic [31:0] count);
      start <= 1'b1;
      req_counter_seconds <= count;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_dates.push_back(calendar_of(count));
      @(negedge clock);
   endtask

   // random gap between bursts, sometimes none
   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (n != 0) start <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_dates.size() != 0) @(negedge clock);
   endtask

   // in-range count built from a calendar date and time
   function automatic logic [31:0] count_of(int unsigned yoff, int unsigned mon,
                                            int unsigned dom, int unsigned sod);
      int unsigned days;
      int unsigned mlens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      days = 0;
      for (int y = 0; y < yoff; y++) days += (y % 4 == 0) ? 366 : 365;
      for (int m = 1; m < mon; m++) days += (m == 2 && yoff % 4 == 0) ? 29 : mlens[m - 1];
      return (days + dom - 1) * 86400 + sod;
   endfunction

   task automatic test_extremes();
      logic [31:0] picks[$];
      picks = '{32'd0, 32'd86399, 32'd86400, LastCount, LastCount + 1,
                32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA};
      foreach (picks[i]) send_count(picks[i]);
      drain();
   endtask

   // leap February, year and month boundaries
   task automatic test_boundaries();
      int unsigned yrs[5] = '{0, 1, 4, 96, 99};
      foreach (yrs[i]) begin
         send_count(count_of(yrs[i], 2, 28, 86399));
         send_count(count_of(yrs[i], 3, 1, 0));
         send_count(count_of(yrs[i], 12, 31, 86399));
      end
      send_count(count_of(4, 2, 29, 43210));
      drain();
   endtask

   // mostly in-range counts, some past 2099 and full-width noise
   task automatic test_random(int unsigned items);
      int unsigned sent;
      int unsigned burst;
      logic [31:0] c;
      sent = 0;
      while (sent < items) begin
         burst = $urandom_range(1, 20);
         for (int k = 0; k < burst && sent < items; k++) begin
            case ($urandom_range(0, 9))
               0: c = $urandom();
               1: c = $urandom_range(32'hFFFF_FFFF, LastCount + 1);
               2: c = count_of($urandom_range(0, 99), $urandom_range(1, 12),
                               $urandom_range(27, 28), $urandom_range(0, 86399));
               default: c = $urandom_range(LastCount, 0);
            endcase
            send_count(c);
            sent++;
         end
         idle_gap();
      end
   endtask

   task automatic test_pause_until_drained();
      test_random(40);
      drain();
      test_random(40);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_extremes();
      test_boundaries();
      test_pause_until_drained();
      test_random(1540);
      drain();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
